// File: rtl/hci_trace_log_framer_top_macros.svh
// Assertion macros for the trace log framer checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef HCI_TRACE_LOG_FRAMER_TOP_MACROS_SVH
`define HCI_TRACE_LOG_FRAMER_TOP_MACROS_SVH

// clocked, masked while reset is asserted
`define HTLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked, also checked while reset is asserted
`define HTLF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/hci_tlf_pkg.sv
// Shared types and constants of the trace log framer.
// No dependencies.
package hci_tlf_pkg;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 8;

  localparam logic [7:0] SyncA      = 8'hF5;
  localparam logic [7:0] SyncB      = 8'h5A;
  localparam logic [7:0] EvtCodeMax = 8'h3E;
  localparam logic [7:0] EvtCodeAny = 8'hFF;

  localparam logic [7:0] PtCmd = 8'h01;
  localparam logic [7:0] PtAcl = 8'h02;
  localparam logic [7:0] PtEvt = 8'h04;

  localparam logic [7:0] FtCmd    = 8'h01;
  localparam logic [7:0] FtAclOut = 8'h02;
  localparam logic [7:0] FtAclIn  = 8'h04;
  localparam logic [7:0] FtEvt    = 8'h08;
  localparam logic [7:0] FtNone   = 8'h00;

  typedef struct packed {
    logic        first;
    logic [7:0]  ptype;
    logic        dir;
    logic [15:0] len;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

endpackage

// File: rtl/hci_tlf_in_reg.sv
// Input holding register of the trace log framer.
// Depends on hci_tlf_pkg.
module hci_tlf_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  hci_tlf_pkg::item_t item_i,
  input  logic               consume_i,
  output logic               valid_o,
  output hci_tlf_pkg::item_t item_o
);
  import hci_tlf_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign s_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/hci_tlf_core.sv
// Filter and byte sequencer of the trace log framer: frame state and checksum.
// Depends on hci_tlf_pkg.
module hci_tlf_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hci_tlf_pkg::item_t item_i,
  input  logic               out_space_i,
  output logic               consume_o,
  output logic               emit_o,
  output hci_tlf_pkg::beat_t beat_o
);
  import hci_tlf_pkg::*;

  // header steps of a first item
  localparam logic [2:0] StepSyncA = 3'd0;
  localparam logic [2:0] StepSyncB = 3'd1;
  localparam logic [2:0] StepType  = 3'd2;
  localparam logic [2:0] StepLenLo = 3'd3;
  localparam logic [2:0] StepLenHi = 3'd4;
  localparam logic [2:0] StepBody  = 3'd5;
  localparam logic [2:0] StepSum   = 3'd6;
  // steps of a payload item
  localparam logic [2:0] StepData  = 3'd0;
  localparam logic [2:0] StepClose = 3'd1;

  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic [2:0]  step_q, step_d;

  logic [7:0] ftype;
  logic       evt_drop, none, last, close;
  logic [7:0] byte_c, sum_cur;

  always_comb begin
    ftype = FtNone;
    if (!item_i.dir) begin
      if (item_i.ptype == PtCmd) ftype = FtCmd;
      else if (item_i.ptype == PtAcl) ftype = FtAclOut;
    end else begin
      if (item_i.ptype == PtAcl) ftype = FtAclIn;
      else if (item_i.ptype == PtEvt) ftype = FtEvt;
    end
  end

  assign evt_drop = (item_i.ptype == PtEvt) && (item_i.data > EvtCodeMax) &&
                    (item_i.data != EvtCodeAny);
  assign none     = item_i.first ? (evt_drop || (ftype == FtNone)) : !open_q;
  assign sum_cur  = (item_i.first && (step_q == StepSyncA)) ? 8'h00 : sum_q;

  always_comb begin
    byte_c = item_i.data;
    last   = 1'b0;
    close  = 1'b0;
    if (item_i.first) begin
      case (step_q)
        StepSyncA: byte_c = SyncA;
        StepSyncB: byte_c = SyncB;
        StepType:  byte_c = ftype;
        StepLenLo: byte_c = item_i.len[7:0];
        StepLenHi: byte_c = item_i.len[15:8];
        StepBody: begin
          if (item_i.len == 16'd0) begin
            byte_c = sum_cur;
            close  = 1'b1;
          end
          last = (item_i.len != 16'd1);
        end
        StepSum: begin
          byte_c = sum_cur;
          close  = 1'b1;
          last   = 1'b1;
        end
        default: begin
          byte_c = sum_cur;
          close  = 1'b1;
          last   = 1'b1;
        end
      endcase
    end else begin
      case (step_q)
        StepData:  last = (left_q != 16'd1);
        StepClose: begin
          byte_c = sum_cur;
          close  = 1'b1;
          last   = 1'b1;
        end
        default: begin
          byte_c = sum_cur;
          close  = 1'b1;
          last   = 1'b1;
        end
      endcase
    end
  end

  assign emit_o    = valid_i && !none && out_space_i;
  assign consume_o = valid_i && (none || (out_space_i && last));
  assign beat_o    = '{data: byte_c, last: close};

  always_comb begin
    open_d = open_q;
    left_d = left_q;
    sum_d  = sum_q;
    step_d = step_q;
    if (valid_i && none && item_i.first) begin
      open_d = 1'b0;
      left_d = 16'd0;
      sum_d  = 8'h00;
    end
    if (emit_o) begin
      step_d = last ? 3'd0 : step_q + 3'd1;
      if (close) begin
        open_d = 1'b0;
        left_d = 16'd0;
        sum_d  = 8'h00;
      end else begin
        sum_d = sum_cur + byte_c;
        if (item_i.first && (step_q == StepBody)) begin
          open_d = last;
          left_d = item_i.len - 16'd1;
        end else if (!item_i.first) begin
          left_d = left_q - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 16'd0;
      sum_q  <= 8'h00;
      step_q <= 3'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
      sum_q  <= sum_d;
      step_q <= step_d;
    end
  end

endmodule

// File: rtl/hci_tlf_out_reg.sv
// Output register of the trace log framer.
// Depends on hci_tlf_pkg.
module hci_tlf_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               emit_i,
  input  hci_tlf_pkg::beat_t beat_i,
  output logic               space_o,
  input  logic               m_ready_i,
  output logic               m_valid_o,
  output hci_tlf_pkg::beat_t beat_o
);
  import hci_tlf_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign space_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      beat_q <= beat_i;
    end
  end

  assign m_valid_o = valid_q;
  assign beat_o    = beat_q;

endmodule

// File: rtl/hci_trace_log_framer_top.sv
// Top level of the trace log framer.
// Depends on hci_tlf_pkg, hci_tlf_in_reg, hci_tlf_core, hci_tlf_out_reg.
//
// Usage:
//   Slave stream carries one packet byte per transaction; tuser flags the
//   first byte of a packet, which also carries type, direction and length.
//   Master stream carries the framed record one byte per transaction; tlast
//   marks the checksum byte that closes a frame.
// Path: the first output byte passes the input holding register and then the
//   output register.
// Throughput: a payload byte yields one output byte, the closing payload byte
//   two (byte plus checksum). A first byte yields six (header plus checksum or
//   header plus byte), seven for a one-byte packet; a dropped packet or an
//   orphan byte yields none. The output register takes one byte per cycle
//   while the master side holds tready high.
// Reset: clears the held input, the output register and the frame state
//   (no packet open, checksum zero).
// Stall: when the master side holds tready low the output byte is held,
//   the sequencer waits (dropped bytes still pass) and the slave side drops tready once its holding
//   register is full.
module hci_trace_log_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] pkt_type, [8] direction, [24:9] length, [32:25] data_byte, rest zero
  input  logic [39:0] s_axis_tdata_i,
  // [0] first_of_packet
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata_o,
  // frame_end
  output logic        m_axis_tlast_o
);
  import hci_tlf_pkg::*;

  item_t in_item, held_item;
  beat_t core_beat, out_beat;
  logic  held_valid, consume, emit, out_space;

  assign in_item = '{first: s_axis_tuser_i,
                     ptype: s_axis_tdata_i[7:0],
                     dir:   s_axis_tdata_i[8],
                     len:   s_axis_tdata_i[24:9],
                     data:  s_axis_tdata_i[32:25]};

  hci_tlf_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .item_i    (in_item),
    .consume_i (consume),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  hci_tlf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .item_i      (held_item),
    .out_space_i (out_space),
    .consume_o   (consume),
    .emit_o      (emit),
    .beat_o      (core_beat)
  );

  hci_tlf_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .emit_i    (emit),
    .beat_i    (core_beat),
    .space_o   (out_space),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .beat_o    (out_beat)
  );

  assign m_axis_tdata_o = out_beat.data;
  assign m_axis_tlast_o = out_beat.last;

endmodule

// File: rtl/hci_tlf_checker.sv
// Port-level checker of the trace log framer, bound to the top level.
// Depends on hci_tlf_pkg and hci_trace_log_framer_top_macros.svh.
`include "hci_trace_log_framer_top_macros.svh"

module hci_tlf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tlast_o
);
  import hci_tlf_pkg::*;

  logic m_xfer;
  logic start_q, second_q;

  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;

  // frame position after a closed frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b1;
      second_q <= 1'b0;
    end else if (m_xfer) begin
      start_q  <= m_axis_tlast_o;
      second_q <= start_q;
    end
  end

  `HTLF_ASSERT_RST(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid_o, "output valid in reset")
  `HTLF_ASSERT(a_hold_on_stall, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output changed while stalled")
  `HTLF_ASSERT(a_frame_sync_a, m_xfer && start_q |-> m_axis_tdata_o == SyncA && !m_axis_tlast_o, "frame does not open with first sync byte")
  `HTLF_ASSERT(a_frame_sync_b, m_xfer && second_q |-> m_axis_tdata_o == SyncB && !m_axis_tlast_o, "second sync byte missing")

endmodule

bind hci_trace_log_framer_top hci_tlf_checker u_hci_tlf_checker (.*);

// File: test/hci_trace_log_framer_checker.sv
// Scoreboard for the trace log framer: watches both streams, predicts the framed
// record for every accepted byte and compares it with the master side.
// Depends on hci_tlf_pkg.
`timescale 1ns / 1ps

module hci_trace_log_framer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          beats_o,
  output int          frames_o
);
  import hci_tlf_pkg::*;

  beat_t       record_q[$];
  logic        rec_open;
  logic [15:0] payload_left;
  logic [7:0]  rec_sum;

  task automatic emit_summed(input logic [7:0] b);
    beat_t bt;
    rec_sum = rec_sum + b;
    bt.data = b;
    bt.last = 1'b0;
    record_q.push_back(bt);
  endtask

  task automatic close_record();
    beat_t bt;
    bt.data = rec_sum;
    bt.last = 1'b1;
    record_q.push_back(bt);
    rec_open     = 1'b0;
    payload_left = '0;
    rec_sum      = '0;
  endtask

  task automatic frame_packet_byte(input item_t it);
    logic [7:0] ftype;
    ftype = FtNone;
    if (it.first) begin
      rec_open     = 1'b0;
      payload_left = '0;
      rec_sum      = '0;
      if (it.ptype == PtEvt && it.data > EvtCodeMax && it.data != EvtCodeAny) return;
      if (!it.dir) begin
        if (it.ptype == PtCmd) ftype = FtCmd;
        else if (it.ptype == PtAcl) ftype = FtAclOut;
      end else begin
        if (it.ptype == PtAcl) ftype = FtAclIn;
        else if (it.ptype == PtEvt) ftype = FtEvt;
      end
      if (ftype == FtNone) return;
      emit_summed(SyncA);
      emit_summed(SyncB);
      emit_summed(ftype);
      emit_summed(it.len[7:0]);
      emit_summed(it.len[15:8]);
      if (it.len == '0) begin
        close_record();
        return;
      end
      emit_summed(it.data);
      payload_left = it.len - 16'd1;
      if (payload_left == '0) close_record();
      else rec_open = 1'b1;
    end else if (rec_open) begin
      emit_summed(it.data);
      payload_left = payload_left - 16'd1;
      if (payload_left == '0) close_record();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t it;
    beat_t exp_b;
    if (!rst_ni) begin
      rec_open     = 1'b0;
      payload_left = '0;
      rec_sum      = '0;
      record_q.delete();
      err_cnt_o    = 0;
      pending_o    = 0;
      beats_o      = 0;
      frames_o     = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        beats_o++;
        if (m_axis_tlast_i) frames_o++;
        if (record_q.size() == 0) begin
          $error("unexpected output transaction: out_byte %h frame_end %b",
                 m_axis_tdata_i, m_axis_tlast_i);
          err_cnt_o++;
        end else begin
          exp_b = record_q.pop_front();
          if (m_axis_tdata_i !== exp_b.data) begin
            $error("out_byte: expected %h, actual %h", exp_b.data, m_axis_tdata_i);
            err_cnt_o++;
          end
          if (m_axis_tlast_i !== exp_b.last) begin
            $error("frame_end: expected %b, actual %b", exp_b.last, m_axis_tlast_i);
            err_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        it.first = s_axis_tuser_i;
        it.ptype = s_axis_tdata_i[7:0];
        it.dir   = s_axis_tdata_i[8];
        it.len   = s_axis_tdata_i[24:9];
        it.data  = s_axis_tdata_i[32:25];
        frame_packet_byte(it);
      end
      pending_o = record_q.size();
    end
  end

endmodule

// File: test/hci_trace_log_framer_top_tb.sv
// Testbench top for hci_trace_log_framer_top: drives packet byte streams with
// random gaps and stalls; hci_trace_log_framer_checker does the prediction.
// Depends on hci_tlf_pkg, hci_trace_log_framer_checker and the framer RTL.
`timescale 1ns / 1ps

module hci_trace_log_framer_top_tb;
  import hci_tlf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int err_cnt;
  int pending;
  int beats;
  int frames;
  int items_in;
  int starts_in;
  bit src_calm;
  bit sink_calm;

  hci_trace_log_framer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  hci_trace_log_framer_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending),
    .beats_o         (beats),
    .frames_o        (frames)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1000000;
    $display("Simulation FAILED");
    $finish;
  end

  // one transaction on the slave side, after a random idle gap
  task automatic send_item(input item_t it);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.first;
    s_tdata  <= {7'd0, it.data, it.len, it.dir, it.ptype};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    items_in++;
    if (it.first) starts_in++;
  endtask

  // header fields of a non-first byte are don't-care, so randomize them
  task automatic send_payload(input int cnt);
    item_t it;
    repeat (cnt) begin
      it.first = 1'b0;
      it.ptype = 8'($urandom_range(0, 255));
      it.dir   = 1'($urandom_range(0, 1));
      it.len   = 16'($urandom_range(0, 65535));
      it.data  = 8'($urandom_range(0, 255));
      send_item(it);
    end
  endtask

  task automatic send_packet(input logic [7:0] ptype, input logic dir,
                             input logic [15:0] len, input logic [7:0] code,
                             input int extra);
    item_t it;
    it.first = 1'b1;
    it.ptype = ptype;
    it.dir   = dir;
    it.len   = len;
    it.data  = code;
    send_item(it);
    send_payload(extra);
  endtask

  initial begin
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int gap;
      if ($urandom_range(0, 39) == 0) sink_calm = ~sink_calm;
      gap = sink_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_tvalid && m_tready));
      @(negedge clk_i);
    end
  end

  initial begin
    int          r;
    int          extra;
    logic [7:0]  pt;
    logic        dr;
    logic [15:0] ln;
    logic [7:0]  cd;

    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tuser   = 1'b0;
    s_tdata   = '0;
    items_in  = 0;
    starts_in = 0;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed
    send_payload(1);                           // orphan byte after reset
    send_packet(PtCmd, 1'b0, 16'h0000, 8'h00, 0);
    send_packet(PtAcl, 1'b0, 16'h0001, 8'hFF, 0);
    send_packet(PtAcl, 1'b1, 16'h0003, 8'hA5, 2);
    send_packet(PtEvt, 1'b1, 16'h0002, EvtCodeMax, 1);
    send_packet(PtEvt, 1'b1, 16'h0002, 8'h3F, 1);  // event code filtered
    send_packet(PtEvt, 1'b1, 16'h0000, EvtCodeAny, 0);
    send_packet(PtEvt, 1'b0, 16'h0001, 8'h10, 0);  // outgoing event dropped
    send_packet(PtCmd, 1'b1, 16'h0001, 8'h10, 0);  // incoming command dropped
    send_packet(8'hFF, 1'b1, 16'hFFFF, 8'h00, 0);
    send_packet(8'h00, 1'b0, 16'h0000, 8'h00, 0);
    send_packet(PtAcl, 1'b1, 16'hFFFF, 8'h5A, 2);  // abandoned by next start
    send_packet(PtCmd, 1'b0, 16'h8000, 8'h81, 1);
    send_packet(8'h03, 1'b1, 16'h7FFF, 8'h7E, 1);  // drop abandons open frame
    send_packet(PtEvt, 1'b1, 16'h0001, 8'hFE, 0);
    send_packet(PtEvt, 1'b1, 16'h0003, 8'h00, 2);

    // random
    while (items_in < 450) begin
      if ($urandom_range(0, 14) == 0) src_calm = ~src_calm;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: begin pt = PtCmd; dr = 1'b0; end
        1: begin pt = PtAcl; dr = 1'b0; end
        2: begin pt = PtAcl; dr = 1'b1; end
        default: begin pt = PtEvt; dr = 1'b1; end
      endcase
      cd = (pt != PtEvt) ? 8'($urandom_range(0, 255)) :
           ($urandom_range(0, 9) == 0) ? EvtCodeAny : 8'($urandom_range(0, 8'h3E));
      if (r < 62) begin
        ln = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(9, 40))
                                         : 16'($urandom_range(0, 8));
        extra = (ln == 0) ? 0 : ln - 1;
        send_packet(pt, dr, ln, cd, extra);
      end else if (r < 72) begin
        ln = 16'($urandom_range(0, 65535));
        extra = $urandom_range(0, 5);
        send_packet(pt, dr, ln, cd, extra);
      end else if (r < 82) begin
        ln = 16'($urandom_range(2, 20));
        extra = $urandom_range(0, ln - 2);
        send_packet(pt, dr, ln, cd, extra);
      end else if (r < 91) begin
        if ($urandom_range(0, 1)) begin
          pt = PtEvt;
          dr = 1'($urandom_range(0, 1));
          cd = 8'($urandom_range(8'h3F, 8'hFE));
        end else begin
          pt = 8'($urandom_range(0, 255));
          dr = 1'($urandom_range(0, 1));
          cd = 8'($urandom_range(0, 255));
        end
        send_packet(pt, dr, 16'($urandom_range(0, 65535)), cd, $urandom_range(0, 3));
      end else begin
        send_payload($urandom_range(1, 3));
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d byte transactions (%0d packet starts).", items_in, starts_in);
    $display("Checked %0d framed bytes over %0d closed frames.", beats, frames);
    if (err_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
